FILE: src/dds_pkg.sv
// dds_pkg: shared types, constants and codes for the diamond-difference sweep block
// no dependencies; imported by the interfaces and every module of the block but dds_ram
package dds_pkg;

    // field widths
    localparam int unsigned FLUX_W  = 32;
    localparam int unsigned XS_W    = 31;
    localparam int unsigned SIZE_W  = 7;
    localparam int unsigned GRP_W   = 5;
    localparam int unsigned COS_W   = 17;
    localparam int unsigned COEF_W  = 30;
    localparam int unsigned DEN_W   = 33;
    localparam int unsigned NUM_W   = 64;
    localparam int unsigned STEP_W  = 7;
    localparam int unsigned CIDX_W  = 3;

    // coefficient cap
    localparam logic [COEF_W-1:0] COEF_MAX = '1;

    // signed 32-bit limits
    localparam logic [FLUX_W-1:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [FLUX_W-1:0] S32_MIN = 32'h8000_0000;

    // divider step counts
    localparam logic [STEP_W-1:0] COEF_STEPS = 7'd34;
    localparam logic [STEP_W-1:0] FLUX_STEPS = 7'd64;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_CELLS_X = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_CELLS_Y = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_CELLS_Z = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_GROUPS  = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_COS_X   = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_COS_Y   = 3'd5;
    localparam logic [CIDX_W-1:0] CFG_COS_Z   = 3'd6;

    // operand select codes: three coefficients, then the flux numerator
    localparam logic [1:0] SEL_A = 2'd0;
    localparam logic [1:0] SEL_B = 2'd1;
    localparam logic [1:0] SEL_C = 2'd2;
    localparam logic [1:0] SEL_N = 2'd3;

    typedef struct packed {
        logic [FLUX_W-1:0] source;
        logic [XS_W-1:0]   total_xs;
        logic [XS_W-1:0]   width_x;
        logic [XS_W-1:0]   width_y;
        logic [XS_W-1:0]   width_z;
        logic [FLUX_W-1:0] inflow_x;
        logic [FLUX_W-1:0] inflow_y;
        logic [FLUX_W-1:0] inflow_z;
    } t_in_word;

    typedef struct packed {
        logic [FLUX_W-1:0] flux;
        logic [FLUX_W-1:0] outflow_x;
        logic [FLUX_W-1:0] outflow_y;
        logic [FLUX_W-1:0] outflow_z;
        logic              sweep_end;
        logic              saturated;
    } t_out_word;

    // controller to datapath
    typedef struct packed {
        logic       load;
        logic       div_go;
        logic       mul;
        logic       acc;
        logic       fin;
        logic [1:0] sel;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_stat;

endpackage

FILE: src/dds_ifs.sv
// dds interfaces: input item, result and configuration write channels
// depends on dds_pkg
interface dds_item_if;
    import dds_pkg::*;
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dds_result_if;
    import dds_pkg::*;
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dds_cfg_if;
    import dds_pkg::*;
    logic              valid;
    logic              ready;
    logic [CIDX_W-1:0] index;
    logic [COS_W-1:0]  data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/dds_ram.sv
// dds_ram: generic single-write, single-read memory with registered read data
// no dependencies
module dds_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: src/dds_div.sv
// dds_div: restoring divider, one quotient bit per cycle
// depends on dds_pkg; the dividend is left-aligned so that i_steps bits are consumed
module dds_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_go,
    input  logic [dds_pkg::NUM_W-1:0]    i_dividend,
    input  logic [dds_pkg::DEN_W-1:0]    i_divisor,
    input  logic [dds_pkg::STEP_W-1:0]   i_steps,
    output logic [dds_pkg::NUM_W-1:0]    o_quot,
    output logic                         o_done
);
    import dds_pkg::*;

    logic [NUM_W-1:0]  r_dq;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [STEP_W-1:0] r_cnt;
    logic              r_done;
    logic [DEN_W:0]    trial;
    logic [DEN_W+1:0]  diff;

    // trial subtract of the shifted remainder
    assign trial = {r_rem, r_dq[NUM_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_cnt <= i_steps;
            end else if (r_cnt != '0) begin
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == STEP_W'(1));
            end
        end
    end

    // quotient and remainder
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_dq  <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_cnt != '0) begin
            if (!diff[DEN_W+1]) begin
                r_rem <= diff[DEN_W-1:0];
                r_dq  <= {r_dq[NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= trial[DEN_W-1:0];
                r_dq  <= {r_dq[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign o_quot = r_dq;
    assign o_done = r_done;
endmodule

FILE: src/dds_ctrl.sv
// dds_ctrl: sequencing state machine for one item
// depends on dds_pkg; drives the datapath through t_cmd and watches t_stat
module dds_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  dds_pkg::t_stat i_stat,
    output dds_pkg::t_cmd  o_cmd
);
    import dds_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DGO  = 3'd1;
    localparam logic [2:0] S_DWT  = 3'd2;
    localparam logic [2:0] S_MUL0 = 3'd3;
    localparam logic [2:0] S_MUL1 = 3'd4;
    localparam logic [2:0] S_MUL2 = 3'd5;
    localparam logic [2:0] S_MUL3 = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    logic [2:0] r_state, n_state;
    logic [1:0] r_sel, n_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= SEL_A;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        n_sel      = r_sel;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.sel  = r_sel;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_sel      = SEL_A;
                    n_state    = S_DGO;
                end
            end
            S_DGO: begin
                o_cmd.div_go = 1'b1;
                n_state      = S_DWT;
            end
            S_DWT: begin
                if (i_stat.div_done) begin
                    if (r_sel == SEL_N) begin
                        n_state = S_FIN;
                    end else if (r_sel == SEL_C) begin
                        n_state = S_MUL0;
                    end else begin
                        n_sel   = r_sel + 1'b1;
                        n_state = S_DGO;
                    end
                end
            end
            S_MUL0: begin
                o_cmd.mul = 1'b1;
                o_cmd.sel = SEL_A;
                n_state   = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul = 1'b1;
                o_cmd.acc = 1'b1;
                o_cmd.sel = SEL_B;
                n_state   = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul = 1'b1;
                o_cmd.acc = 1'b1;
                o_cmd.sel = SEL_C;
                n_state   = S_MUL3;
            end
            S_MUL3: begin
                o_cmd.acc = 1'b1;
                n_sel     = SEL_N;
                n_state   = S_DGO;
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

FILE: src/dds_dp.sv
// dds_dp: datapath with configuration registers, sweep counters, face buffers,
// shared divider, multiply-accumulate and the result register; depends on dds_pkg,
// dds_ram and dds_div
module dds_dp #(
    parameter int unsigned MAX_CELLS_X = 64,
    parameter int unsigned MAX_CELLS_Y = 64,
    parameter int unsigned MAX_CELLS_Z = 64,
    parameter int unsigned MAX_GROUPS  = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [dds_pkg::CIDX_W-1:0]  i_cfg_index,
    input  logic [dds_pkg::COS_W-1:0]   i_cfg_data,
    input  dds_pkg::t_in_word           i_in,
    input  dds_pkg::t_cmd               i_cmd,
    output dds_pkg::t_stat              o_stat,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output dds_pkg::t_out_word          o_out
);
    import dds_pkg::*;

    localparam int unsigned XW  = MAX_CELLS_X > 1 ? $clog2(MAX_CELLS_X) : 1;
    localparam int unsigned YW  = MAX_CELLS_Y > 1 ? $clog2(MAX_CELLS_Y) : 1;
    localparam int unsigned ZW  = MAX_CELLS_Z > 1 ? $clog2(MAX_CELLS_Z) : 1;
    localparam int unsigned GW  = MAX_GROUPS > 1 ? $clog2(MAX_GROUPS) : 1;
    localparam int unsigned LD  = MAX_CELLS_X * MAX_GROUPS;
    localparam int unsigned PD  = MAX_CELLS_Y * MAX_CELLS_X * MAX_GROUPS;
    localparam int unsigned LAW = LD > 1 ? $clog2(LD) : 1;
    localparam int unsigned PAW = PD > 1 ? $clog2(PD) : 1;
    localparam int unsigned LW  = 9;

    // configuration registers
    logic [SIZE_W-1:0] r_cells_x, r_cells_y, r_cells_z;
    logic [GRP_W-1:0]  r_groups;
    logic [COS_W-1:0]  r_cos_x, r_cos_y, r_cos_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells_x <= SIZE_W'(1);
            r_cells_y <= SIZE_W'(1);
            r_cells_z <= SIZE_W'(1);
            r_groups  <= GRP_W'(1);
            r_cos_x   <= COS_W'(32768);
            r_cos_y   <= COS_W'(32768);
            r_cos_z   <= COS_W'(32768);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CELLS_X: r_cells_x <= i_cfg_data[SIZE_W-1:0];
                CFG_CELLS_Y: r_cells_y <= i_cfg_data[SIZE_W-1:0];
                CFG_CELLS_Z: r_cells_z <= i_cfg_data[SIZE_W-1:0];
                CFG_GROUPS:  r_groups  <= i_cfg_data[GRP_W-1:0];
                CFG_COS_X:   r_cos_x   <= i_cfg_data;
                CFG_COS_Y:   r_cos_y   <= i_cfg_data;
                CFG_COS_Z:   r_cos_z   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective sizes: zero counts as one, clamp at the build maximum
    function automatic logic [LW-1:0] lim(input logic [LW-1:0] v, input logic [LW-1:0] m);
        logic [LW-1:0] r;
        r = v;
        if (v == '0) r = LW'(1);
        else if (v > m) r = m;
        return r;
    endfunction

    logic [LW-1:0] nx, ny, nz, ng;
    assign nx = lim(LW'(r_cells_x), LW'(MAX_CELLS_X));
    assign ny = lim(LW'(r_cells_y), LW'(MAX_CELLS_Y));
    assign nz = lim(LW'(r_cells_z), LW'(MAX_CELLS_Z));
    assign ng = lim(LW'(r_groups),  LW'(MAX_GROUPS));

    // sweep counters
    logic [XW-1:0] r_px;
    logic [YW-1:0] r_py;
    logic [ZW-1:0] r_pz;
    logic [GW-1:0] r_g;
    logic          wrap_g, wrap_x, wrap_y, wrap_z;

    assign wrap_g = (LW'(r_g)  + LW'(1)) >= ng;
    assign wrap_x = (LW'(r_px) + LW'(1)) >= nx;
    assign wrap_y = (LW'(r_py) + LW'(1)) >= ny;
    assign wrap_z = (LW'(r_pz) + LW'(1)) >= nz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px <= '0;
            r_py <= '0;
            r_pz <= '0;
            r_g  <= '0;
        end else if (i_cmd.fin) begin
            if (!wrap_g) begin
                r_g <= r_g + 1'b1;
            end else begin
                r_g <= '0;
                if (!wrap_x) begin
                    r_px <= r_px + 1'b1;
                end else begin
                    r_px <= '0;
                    if (!wrap_y) begin
                        r_py <= r_py + 1'b1;
                    end else begin
                        r_py <= '0;
                        r_pz <= wrap_z ? '0 : r_pz + 1'b1;
                    end
                end
            end
        end
    end

    // face buffer addresses
    logic [GW-1:0]  x_addr;
    logic [LAW-1:0] y_addr;
    logic [PAW-1:0] z_addr;
    assign x_addr = r_g;
    assign y_addr = LAW'(LAW'(r_px) * LAW'(MAX_GROUPS) + LAW'(r_g));
    assign z_addr = PAW'((PAW'(r_py) * PAW'(MAX_CELLS_X) + PAW'(r_px)) * PAW'(MAX_GROUPS)
                         + PAW'(r_g));

    logic [FLUX_W-1:0] x_q, y_q, z_q;
    logic [FLUX_W-1:0] ox, oy, oz;

    dds_ram #(.WIDTH(FLUX_W), .DEPTH(MAX_GROUPS)) u_xreg (
        .i_clk(i_clk), .i_we(i_cmd.fin), .i_waddr(x_addr), .i_wdata(ox),
        .i_raddr(x_addr), .o_rdata(x_q)
    );
    dds_ram #(.WIDTH(FLUX_W), .DEPTH(LD)) u_yline (
        .i_clk(i_clk), .i_we(i_cmd.fin), .i_waddr(y_addr), .i_wdata(oy),
        .i_raddr(y_addr), .o_rdata(y_q)
    );
    dds_ram #(.WIDTH(FLUX_W), .DEPTH(PD)) u_zplane (
        .i_clk(i_clk), .i_we(i_cmd.fin), .i_waddr(z_addr), .i_wdata(oz),
        .i_raddr(z_addr), .o_rdata(z_q)
    );

    // captured item and working registers
    t_in_word          r_in;
    logic [COEF_W-1:0] r_a, r_b, r_c;
    logic [FLUX_W-1:0] r_fl, r_ff, r_fb;
    logic [NUM_W-1:0]  r_num;
    logic [62:0]       r_prod;
    logic [NUM_W-1:0]  r_quo;
    logic              r_sat;

    // divider operands
    logic [NUM_W-1:0]  div_dd, num_mag, quo;
    logic [DEN_W-1:0]  div_dv, den;
    logic [STEP_W-1:0] div_st;
    logic              div_done;

    assign den     = DEN_W'(r_a) + DEN_W'(r_b) + DEN_W'(r_c) + DEN_W'(r_in.total_xs);
    assign num_mag = r_num[NUM_W-1] ? (~r_num + 1'b1) : r_num;

    always_comb begin
        case (i_cmd.sel)
            SEL_A: begin
                div_dd = {r_cos_x, 47'd0};
                div_dv = DEN_W'(r_in.width_x);
                div_st = COEF_STEPS;
            end
            SEL_B: begin
                div_dd = {r_cos_y, 47'd0};
                div_dv = DEN_W'(r_in.width_y);
                div_st = COEF_STEPS;
            end
            SEL_C: begin
                div_dd = {r_cos_z, 47'd0};
                div_dv = DEN_W'(r_in.width_z);
                div_st = COEF_STEPS;
            end
            default: begin
                div_dd = num_mag;
                div_dv = den;
                div_st = FLUX_STEPS;
            end
        endcase
    end

    dds_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(i_cmd.div_go),
        .i_dividend(div_dd), .i_divisor(div_dv), .i_steps(div_st),
        .o_quot(quo), .o_done(div_done)
    );

    // coefficient cap; a zero width gives an all-ones quotient and lands here too
    logic              coef_big;
    logic [COEF_W-1:0] coef_val;
    assign coef_big = quo[NUM_W-1:COEF_W] != '0;
    assign coef_val = coef_big ? COEF_MAX : quo[COEF_W-1:0];

    // multiplier operands and incoming face choice
    logic [COEF_W-1:0] m_coef;
    logic [FLUX_W-1:0] m_face;
    always_comb begin
        case (i_cmd.sel)
            SEL_A: begin
                m_coef = r_a;
                m_face = (r_px == '0) ? r_in.inflow_x : x_q;
            end
            SEL_B: begin
                m_coef = r_b;
                m_face = (r_py == '0) ? r_in.inflow_y : y_q;
            end
            default: begin
                m_coef = r_c;
                m_face = (r_pz == '0) ? r_in.inflow_z : z_q;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in  <= i_in;
            r_num <= {{16{i_in.source[FLUX_W-1]}}, i_in.source, 16'd0};
        end else if (i_cmd.acc) begin
            r_num <= r_num + {r_prod[62], r_prod};
        end
        if (i_cmd.mul) begin
            r_prod <= $signed({1'b0, m_coef}) * $signed(m_face);
            case (i_cmd.sel)
                SEL_A:   r_fl <= m_face;
                SEL_B:   r_ff <= m_face;
                default: r_fb <= m_face;
            endcase
        end
        if (div_done) begin
            case (i_cmd.sel)
                SEL_A:   r_a   <= coef_val;
                SEL_B:   r_b   <= coef_val;
                SEL_C:   r_c   <= coef_val;
                default: r_quo <= quo;
            endcase
        end
    end

    // saturation flag over the item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sat <= 1'b0;
        end else if (div_done && i_cmd.sel != SEL_N && coef_big) begin
            r_sat <= 1'b1;
        end
    end

    // flux from quotient with sign and clipping
    logic              neg;
    logic [FLUX_W-1:0] psi;
    logic              psi_sat;
    always_comb begin
        neg     = r_num[NUM_W-1];
        psi_sat = 1'b0;
        if (den == '0) begin
            psi     = neg ? S32_MIN : S32_MAX;
            psi_sat = 1'b1;
        end else if (!neg) begin
            if (r_quo > NUM_W'(S32_MAX)) begin
                psi     = S32_MAX;
                psi_sat = 1'b1;
            end else begin
                psi = r_quo[FLUX_W-1:0];
            end
        end else begin
            if (r_quo > NUM_W'(S32_MIN)) begin
                psi     = S32_MIN;
                psi_sat = 1'b1;
            end else begin
                psi = ~r_quo[FLUX_W-1:0] + 1'b1;
            end
        end
    end

    // outgoing faces 2*flux - incoming, clipped
    function automatic logic [FLUX_W:0] outf(input logic [FLUX_W-1:0] p,
                                             input logic [FLUX_W-1:0] f);
        logic [FLUX_W+1:0] t;
        logic [FLUX_W:0]   r;
        t = {p[FLUX_W-1], p, 1'b0} - {{2{f[FLUX_W-1]}}, f};
        if (t[FLUX_W+1:FLUX_W-1] == 3'b000 || t[FLUX_W+1:FLUX_W-1] == 3'b111) begin
            r = {1'b0, t[FLUX_W-1:0]};
        end else begin
            r = {1'b1, t[FLUX_W+1] ? S32_MIN : S32_MAX};
        end
        return r;
    endfunction

    logic [FLUX_W:0] ex, ey, ez;
    assign ex = outf(psi, r_fl);
    assign ey = outf(psi, r_ff);
    assign ez = outf(psi, r_fb);
    assign ox = ex[FLUX_W-1:0];
    assign oy = ey[FLUX_W-1:0];
    assign oz = ez[FLUX_W-1:0];

    // result register
    logic      r_out_valid;
    t_out_word r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fin) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_out.flux      <= psi;
            r_out.outflow_x <= ox;
            r_out.outflow_y <= oy;
            r_out.outflow_z <= oz;
            r_out.sweep_end <= wrap_g && wrap_x && wrap_y && wrap_z;
            r_out.saturated <= r_sat || psi_sat || ex[FLUX_W] || ey[FLUX_W]
                               || ez[FLUX_W];
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out           = r_out;
    assign o_stat.div_done = div_done;
    assign o_stat.out_free = !r_out_valid || i_out_ready;
endmodule

FILE: src/diamond_difference_sweep_3d_top.sv
// diamond_difference_sweep_3d_top: top level joining controller and datapath
// depends on dds_pkg, dds_ifs, dds_ctrl and dds_dp
//
//  channel   dir  carries                                  handshake
//  i_item    in   source, total_xs, widths, three inflows   valid/ready
//  o_result  out  flux, three outflows, sweep_end, saturated valid/ready
//  i_cfg     in   register index and value                  valid/ready, always ready
//
// one word takes three 34-step coefficient divisions, the multiply-accumulate of the
// three incoming faces and one 64-step flux division on the shared one-bit-per-cycle
// divider, then the write-back.
// reset is synchronous; the face buffers hold no reset value and are filled by the sweep.
// a waiting result sits in the output register while the next word is taken;
// write-back stalls only if that register is still full.
module diamond_difference_sweep_3d_top #(
    parameter int unsigned MAX_CELLS_X = 64,
    parameter int unsigned MAX_CELLS_Y = 64,
    parameter int unsigned MAX_CELLS_Z = 64,
    parameter int unsigned MAX_GROUPS  = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    dds_item_if.sink     i_item,
    dds_result_if.source o_result,
    dds_cfg_if.sink      i_cfg
);
    import dds_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign i_cfg.ready = 1'b1;

    // sequencing
    dds_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_item.valid), .o_in_ready(i_item.ready),
        .i_stat(stat), .o_cmd(cmd)
    );

    // arithmetic and storage
    dds_dp #(
        .MAX_CELLS_X(MAX_CELLS_X), .MAX_CELLS_Y(MAX_CELLS_Y),
        .MAX_CELLS_Z(MAX_CELLS_Z), .MAX_GROUPS(MAX_GROUPS)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg.valid), .i_cfg_index(i_cfg.index), .i_cfg_data(i_cfg.data),
        .i_in(i_item.data), .i_cmd(cmd), .o_stat(stat),
        .o_out_valid(o_result.valid), .i_out_ready(o_result.ready),
        .o_out(o_result.data)
    );
endmodule
